[src/dar_pkg.sv]
// shared types and constants for the difference array range update block
// no dependencies; imported by every other file of the block but dar_ram
package dar_pkg;

  localparam int MAX_ELEMENTS  = 256;
  localparam int ELEMENT_WIDTH = 32;
  localparam int ADDR_WIDTH    = $clog2(MAX_ELEMENTS);
  localparam int LEN_WIDTH     = $clog2(MAX_ELEMENTS + 1);

  localparam int OP_WIDTH     = 2;
  localparam int STATUS_WIDTH = 2;

  // stream payload widths, padded to whole bytes
  localparam int IN_FIELD_BITS   = 2 * ADDR_WIDTH + ELEMENT_WIDTH;
  localparam int IN_TDATA_WIDTH  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = ((ELEMENT_WIDTH + 7) / 8) * 8;

  localparam logic [OP_WIDTH-1:0] OP_LOAD      = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_RANGE_ADD = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_RESTORE   = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_BAD_RANGE  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_LOAD_FULL  = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY      = 2'd3;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [ADDR_WIDTH-1:0]    addr_t;
  typedef logic [LEN_WIDTH-1:0]     len_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0] op;
    addr_t               left;
    addr_t               right;
    elem_t               data;
  } item_t;

  typedef struct packed {
    logic                    valid;
    elem_t                   value;
    logic                    last;
    logic [STATUS_WIDTH-1:0] status;
  } result_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    elem_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

[src/difference_array_range_update.sv]
// difference array range update, top level: stream ports, length register,
// output register; depends on dar_pkg, dar_ctrl and dar_ram
//
// one item is worked on at a time. a load is written in the issue state, a
// range add reads entry left there and writes it in add1, and a closing entry
// right+1 inside the array gets its own read-modify-write, read in add1 and
// written in add2; a restore reads in the issue state and sums in the restore
// state, as the difference ram has a single registered read port. a finished
// result sits in the output register, and the next item is taken while it
// waits; the block only stalls if a second result is ready before the first
// is taken. ram entries are not cleared after reset, and may be read unwritten.
// the length register may be written only while no item is in flight.
module difference_array_range_update (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // left_index, right_index, data_value
  input  logic [dar_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,
  // operation
  input  logic [dar_pkg::OP_WIDTH-1:0]        s_tuser,
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // element_value
  output logic [dar_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
  // element_last
  output logic                                m_tlast,
  // status
  output logic [dar_pkg::STATUS_WIDTH-1:0]    m_tuser,
  // array_length register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dar_pkg::LEN_WIDTH-1:0]       cfg_data
);
  import dar_pkg::*;

  len_t     array_length;
  len_t     len;
  item_t    in_item;
  result_t  res;
  mem_req_t mem_req;
  elem_t    mem_rdata;
  logic     out_free;

  // length register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      array_length <= cfg_data;
    end
  end

  // oversized lengths saturate to the ram depth
  assign len = (array_length > len_t'(MAX_ELEMENTS)) ? len_t'(MAX_ELEMENTS) : array_length;

  // unpack the input item, lowest field first
  assign in_item.op    = s_tuser;
  assign in_item.left  = s_tdata[ADDR_WIDTH-1:0];
  assign in_item.right = s_tdata[2*ADDR_WIDTH-1:ADDR_WIDTH];
  assign in_item.data  = s_tdata[IN_FIELD_BITS-1:2*ADDR_WIDTH];

  // output slot can take a result this cycle
  assign out_free = !m_tvalid || m_tready;

  dar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .len       (len),
    .out_free  (out_free),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // difference store
  dar_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_diff_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // output register, parts the sequencer from the result stream
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= OUT_TDATA_WIDTH'(res.value);
      m_tlast <= res.last;
      m_tuser <= res.status;
    end
  end

endmodule

[src/dar_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/dar_ctrl.sv]
// sequencer: decodes one item, drives read-modify-write on the difference ram,
// keeps the load and restore pointers; depends on dar_pkg
module dar_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dar_pkg::item_t    in_item,
  input  dar_pkg::len_t     len,
  input  logic              out_free,
  output dar_pkg::result_t  res,
  output dar_pkg::mem_req_t mem_req,
  input  dar_pkg::elem_t    mem_rdata
);
  import dar_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ISSUE   = 3'd1;
  localparam logic [2:0] S_ADD1    = 3'd2;
  localparam logic [2:0] S_ADD2    = 3'd3;
  localparam logic [2:0] S_RESTORE = 3'd4;

  logic [2:0] state, state_next;
  item_t      item, item_next;
  len_t       load_pointer, load_pointer_next;
  elem_t      previous_loaded, previous_loaded_next;
  len_t       restore_pointer, restore_pointer_next;
  elem_t      running_sum, running_sum_next;

  len_t  right_plus;
  logic  range_ok;
  logic  second_needed;
  elem_t sum;

  assign right_plus    = {1'b0, item.right} + len_t'(1);
  assign range_ok      = (item.left <= item.right) && ({1'b0, item.right} < len);
  assign second_needed = right_plus < len;
  assign sum           = running_sum + mem_rdata;

  always_comb begin
    state_next           = state;
    item_next            = item;
    load_pointer_next    = load_pointer;
    previous_loaded_next = previous_loaded;
    restore_pointer_next = restore_pointer;
    running_sum_next     = running_sum;
    mem_req              = '0;
    res                  = '0;
    in_ready             = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_next  = in_item;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (item.op)
          OP_LOAD: begin
            if (out_free) begin
              res.valid  = 1'b1;
              state_next = S_IDLE;
              if (load_pointer >= len) begin
                res.status = ST_LOAD_FULL;
              end else begin
                mem_req.we           = 1'b1;
                mem_req.waddr        = load_pointer[ADDR_WIDTH-1:0];
                mem_req.wdata        = item.data - previous_loaded;
                previous_loaded_next = item.data;
                load_pointer_next    = load_pointer + len_t'(1);
              end
            end
          end
          OP_RANGE_ADD: begin
            if (!range_ok) begin
              if (out_free) begin
                res.valid  = 1'b1;
                res.status = ST_BAD_RANGE;
                state_next = S_IDLE;
              end
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = item.left;
              state_next    = S_ADD1;
            end
          end
          OP_RESTORE: begin
            if (len == '0) begin
              if (out_free) begin
                res.valid  = 1'b1;
                res.status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              mem_req.re = 1'b1;
              // length was cut to or below the pointer: start the sweep over
              if (restore_pointer >= len) begin
                restore_pointer_next = '0;
                running_sum_next     = '0;
                mem_req.raddr        = '0;
              end else begin
                mem_req.raddr = restore_pointer[ADDR_WIDTH-1:0];
              end
              state_next = S_RESTORE;
            end
          end
          default: begin
            if (out_free) begin
              res.valid  = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_ADD1: begin
        if (second_needed) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = item.left;
          mem_req.wdata = mem_rdata + item.data;
          mem_req.re    = 1'b1;
          mem_req.raddr = right_plus[ADDR_WIDTH-1:0];
          state_next    = S_ADD2;
        end else if (out_free) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = item.left;
          mem_req.wdata = mem_rdata + item.data;
          res.valid     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ADD2: begin
        if (out_free) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = right_plus[ADDR_WIDTH-1:0];
          mem_req.wdata = mem_rdata - item.data;
          res.valid     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RESTORE: begin
        if (out_free) begin
          res.valid  = 1'b1;
          res.value  = sum;
          state_next = S_IDLE;
          if ((restore_pointer + len_t'(1)) == len) begin
            res.last             = 1'b1;
            restore_pointer_next = '0;
            running_sum_next     = '0;
            load_pointer_next    = '0;
            previous_loaded_next = '0;
          end else begin
            restore_pointer_next = restore_pointer + len_t'(1);
            running_sum_next     = sum;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      load_pointer    <= '0;
      previous_loaded <= '0;
      restore_pointer <= '0;
      running_sum     <= '0;
    end else begin
      state           <= state_next;
      load_pointer    <= load_pointer_next;
      previous_loaded <= previous_loaded_next;
      restore_pointer <= restore_pointer_next;
      running_sum     <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

[src/dar_checker.sv]
// port-level checks for difference_array_range_update, bound to the top level
// depends on dar_pkg
module dar_port_checks (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [dar_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
  input logic                                m_tlast,
  input logic [dar_pkg::STATUS_WIDTH-1:0]    m_tuser
);
  import dar_pkg::*;

  // the final restored element always comes with an ok status
  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == ST_OK)
    else $error("last element flagged with a non-ok status");

  // a flagged item carries no element and no last mark
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0) && !m_tlast)
    else $error("flagged result carries data");

  // one item at a time: busy right after an item is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind difference_array_range_update dar_port_checks u_dar_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
